// ===== hdl/fat_chain_engine_unit_defines.svh =====
// Assertion macros for the FAT chain engine.
// No dependencies; taken in by the top level.
`ifndef FAT_CHAIN_ENGINE_UNIT_DEFINES_SVH
`define FAT_CHAIN_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define FCE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define FCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fce_pkg.sv =====
// Package for the FAT chain engine: item types, microcode format and program.
// No dependencies.
package fce_pkg;

    localparam int unsigned DefDepth        = 8192;
    localparam logic [15:0] EndMark         = 16'hFFFF;
    localparam logic [13:0] BlockCountReset = 14'd8192;
    localparam int unsigned CfgAddrWidth    = 3;

    localparam logic [2:0] FnLoad  = 3'd0;
    localparam logic [2:0] FnRead  = 3'd1;
    localparam logic [2:0] FnAlloc = 3'd2;
    localparam logic [2:0] FnFree  = 3'd3;
    localparam logic [2:0] FnLast  = 3'd4;
    localparam logic [2:0] FnWalk  = 3'd5;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] chain_index;
        logic [15:0] entry_value;
        logic [15:0] block_steps;
    } t_in_item;

    typedef struct packed {
        logic [15:0] result_index;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFREE  = 2'd1,
        ST_PASTEND = 2'd2,
        ST_BAD     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        A_NOP,
        A_RD_IDX,
        A_RD_CNT,
        A_WR_IDX_VAL,
        A_WR_TAIL,
        A_WR_SLOT_END,
        A_CLR_ADV,
        A_ADV,
        A_SCAN
    } t_act;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IDX_END,
        C_IDX_GE_N,
        C_TAIL_BAD,
        C_WALK_BAD,
        C_CNT_GE_N,
        C_RD_NZ,
        C_RD_END,
        C_RD_NOT_END,
        C_LINK_OK,
        C_CNT_GE_STEPS
    } t_cond;

    typedef enum logic [2:0] {
        RS_ZERO,
        RS_IDX,
        RS_RD,
        RS_CNT,
        RS_END
    } t_rsel;

    typedef logic [4:0] t_pc;

    typedef struct packed {
        t_act    act;
        t_cond   cond;
        t_pc     target;
        logic    done;
        t_rsel   rsel;
        t_status st;
    } t_uword;

    typedef struct packed {
        logic idx_end;
        logic idx_ge_n;
        logic cnt_ge_n;
        logic cnt1_ge_n;
        logic cnt_ge_steps;
        logic rd_zero;
        logic rd_end;
        logic rd_ge_n;
    } t_flags;

    // program labels
    localparam t_pc PcBad     = 5'd0;
    localparam t_pc PcNoFree  = 5'd1;
    localparam t_pc PcPastEnd = 5'd2;
    localparam t_pc PcOkZero  = 5'd3;
    localparam t_pc PcOkEnd   = 5'd4;
    localparam t_pc PcLoad    = 5'd5;
    localparam t_pc PcRead    = 5'd7;
    localparam t_pc PcAlloc   = 5'd9;
    localparam t_pc PcScan    = 5'd10;
    localparam t_pc PcFree    = 5'd14;
    localparam t_pc PcFreeRd  = 5'd15;
    localparam t_pc PcLast    = 5'd18;
    localparam t_pc PcLastRd  = 5'd19;
    localparam t_pc PcLastHit = 5'd23;
    localparam t_pc PcWalk    = 5'd24;
    localparam t_pc PcWalkEnd = 5'd28;

    function automatic t_uword mk(t_act a, t_cond c, t_pc t, logic d, t_rsel r, t_status s);
        t_uword w;
        w.act    = a;
        w.cond   = c;
        w.target = t;
        w.done   = d;
        w.rsel   = r;
        w.st     = s;
        return w;
    endfunction

    function automatic t_uword step(t_act a, t_cond c, t_pc t);
        return mk(a, c, t, 1'b0, RS_ZERO, ST_OK);
    endfunction

    function automatic t_uword fin(t_act a, t_rsel r, t_status s);
        return mk(a, C_NEVER, PcBad, 1'b1, r, s);
    endfunction

    function automatic t_uword ucode(t_pc pc);
        t_uword w;
        case (pc)
            5'd0:  w = fin(A_NOP, RS_ZERO, ST_BAD);
            5'd1:  w = fin(A_NOP, RS_ZERO, ST_NOFREE);
            5'd2:  w = fin(A_NOP, RS_END, ST_PASTEND);
            5'd3:  w = fin(A_NOP, RS_ZERO, ST_OK);
            5'd4:  w = fin(A_NOP, RS_END, ST_OK);
            // load
            5'd5:  w = step(A_NOP, C_IDX_GE_N, PcBad);
            5'd6:  w = fin(A_WR_IDX_VAL, RS_ZERO, ST_OK);
            // read
            5'd7:  w = step(A_RD_IDX, C_IDX_GE_N, PcBad);
            5'd8:  w = fin(A_NOP, RS_RD, ST_OK);
            // allocate: scan for the lowest free entry
            5'd9:  w = step(A_NOP, C_TAIL_BAD, PcBad);
            5'd10: w = step(A_RD_CNT, C_CNT_GE_N, PcNoFree);
            5'd11: w = step(A_SCAN, C_RD_NZ, PcScan);
            5'd12: w = step(A_WR_TAIL, C_NEVER, PcBad);
            5'd13: w = fin(A_WR_SLOT_END, RS_CNT, ST_OK);
            // free chain
            5'd14: w = step(A_NOP, C_IDX_END, PcOkZero);
            5'd15: w = step(A_RD_IDX, C_WALK_BAD, PcBad);
            5'd16: w = step(A_CLR_ADV, C_RD_NOT_END, PcFreeRd);
            5'd17: w = fin(A_NOP, RS_ZERO, ST_OK);
            // find last
            5'd18: w = step(A_NOP, C_IDX_END, PcOkEnd);
            5'd19: w = step(A_RD_IDX, C_IDX_GE_N, PcBad);
            5'd20: w = step(A_NOP, C_RD_END, PcLastHit);
            5'd21: w = step(A_ADV, C_LINK_OK, PcLastRd);
            5'd22: w = fin(A_NOP, RS_ZERO, ST_BAD);
            5'd23: w = fin(A_NOP, RS_IDX, ST_OK);
            // walk
            5'd24: w = step(A_NOP, C_CNT_GE_STEPS, PcWalkEnd);
            5'd25: w = step(A_NOP, C_IDX_END, PcPastEnd);
            5'd26: w = step(A_RD_IDX, C_WALK_BAD, PcBad);
            5'd27: w = step(A_ADV, C_ALWAYS, PcWalk);
            5'd28: w = step(A_NOP, C_TAIL_BAD, PcBad);
            5'd29: w = fin(A_NOP, RS_IDX, ST_OK);
            default: w = fin(A_NOP, RS_ZERO, ST_BAD);
        endcase
        return w;
    endfunction

    function automatic t_pc entry_pc(logic [2:0] func);
        t_pc p;
        case (func)
            FnLoad:  p = PcLoad;
            FnRead:  p = PcRead;
            FnAlloc: p = PcAlloc;
            FnFree:  p = PcFree;
            FnLast:  p = PcLast;
            FnWalk:  p = PcWalk;
            default: p = PcBad;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/fce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fce_ram #(
    parameter int unsigned Width = 16,
    parameter int unsigned Depth = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/fce_seq.sv =====
// Microcode sequencer: step counter, program ROM lookup and branch logic.
// Depends on fce_pkg.
module fce_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2:0]     i_func,
    input  fce_pkg::t_flags i_flags,
    input  logic           i_out_free,
    output logic           o_busy,
    output logic           o_go,
    output fce_pkg::t_uword o_uword
);
    import fce_pkg::*;

    t_pc    r_pc;
    logic   r_busy;
    t_uword w_uw;
    logic   w_taken;
    logic   w_go;

    assign w_uw = ucode(r_pc);

    always_comb begin
        case (w_uw.cond)
            C_NEVER:        w_taken = 1'b0;
            C_ALWAYS:       w_taken = 1'b1;
            C_IDX_END:      w_taken = i_flags.idx_end;
            C_IDX_GE_N:     w_taken = i_flags.idx_ge_n;
            C_TAIL_BAD:     w_taken = !i_flags.idx_end && i_flags.idx_ge_n;
            C_WALK_BAD:     w_taken = i_flags.idx_ge_n || i_flags.cnt_ge_n;
            C_CNT_GE_N:     w_taken = i_flags.cnt_ge_n;
            C_RD_NZ:        w_taken = !i_flags.rd_zero;
            C_RD_END:       w_taken = i_flags.rd_end;
            C_RD_NOT_END:   w_taken = !i_flags.rd_end;
            C_LINK_OK:      w_taken = !i_flags.rd_ge_n && !i_flags.cnt1_ge_n;
            C_CNT_GE_STEPS: w_taken = i_flags.cnt_ge_steps;
            default:        w_taken = 1'b0;
        endcase
    end

    // a finishing step waits for room in the output register
    assign w_go = r_busy && (!w_uw.done || i_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PcBad;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_pc   <= entry_pc(i_func);
        end else if (w_go) begin
            if (w_uw.done) begin
                r_busy <= 1'b0;
            end else if (w_taken) begin
                r_pc <= w_uw.target;
            end else begin
                r_pc <= r_pc + t_pc'(1);
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_go    = w_go;
    assign o_uword = w_uw;

endmodule

// ===== hdl/fce_path.sv =====
// Datapath: index and counter registers, link memory, flags and result register.
// Depends on fce_pkg and fce_ram.
module fce_path #(
    parameter int unsigned TABLE_DEPTH = fce_pkg::DefDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  fce_pkg::t_in_item i_item,
    input  logic [15:0]       i_n_used,
    input  fce_pkg::t_uword   i_uword,
    input  logic              i_go,
    output fce_pkg::t_flags   o_flags,
    output logic              o_out_free,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output fce_pkg::t_out_item o_out_item
);
    import fce_pkg::*;

    localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

    logic [15:0] r_idx;
    logic [15:0] r_cnt;
    logic [15:0] r_steps;
    logic [15:0] r_val;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic             w_we;
    logic [AddrW-1:0] w_waddr;
    logic [15:0]      w_wdata;
    logic             w_re;
    logic [AddrW-1:0] w_raddr;
    logic [15:0]      w_rd;
    logic [15:0]      w_res;
    logic             w_out_free;
    t_flags           w_flags;

    fce_ram #(
        .Width (16),
        .Depth (TABLE_DEPTH)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    always_comb begin
        w_flags.idx_end      = r_idx == EndMark;
        w_flags.idx_ge_n     = r_idx >= i_n_used;
        w_flags.cnt_ge_n     = r_cnt >= i_n_used;
        w_flags.cnt1_ge_n    = ({1'b0, r_cnt} + 17'd1) >= {1'b0, i_n_used};
        w_flags.cnt_ge_steps = r_cnt >= r_steps;
        w_flags.rd_zero      = w_rd == 16'd0;
        w_flags.rd_end       = w_rd == EndMark;
        w_flags.rd_ge_n      = w_rd >= i_n_used;
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AddrW-1:0];
        w_wdata = 16'd0;
        w_re    = 1'b0;
        w_raddr = r_idx[AddrW-1:0];
        case (i_uword.act)
            A_RD_IDX: begin
                w_re = i_go;
            end
            A_RD_CNT: begin
                w_re    = i_go;
                w_raddr = r_cnt[AddrW-1:0];
            end
            A_WR_IDX_VAL: begin
                w_we    = i_go;
                w_wdata = r_val;
            end
            A_WR_TAIL: begin
                w_we    = i_go && !w_flags.idx_end;
                w_wdata = r_cnt;
            end
            A_WR_SLOT_END: begin
                w_we    = i_go;
                w_waddr = r_cnt[AddrW-1:0];
                w_wdata = EndMark;
            end
            A_CLR_ADV: begin
                w_we = i_go;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx   <= i_item.chain_index;
            r_val   <= i_item.entry_value;
            r_steps <= i_item.block_steps;
            r_cnt   <= 16'd0;
        end else if (i_go) begin
            case (i_uword.act)
                A_CLR_ADV, A_ADV: begin
                    r_idx <= w_rd;
                    r_cnt <= r_cnt + 16'd1;
                end
                A_SCAN: begin
                    if (!w_flags.rd_zero) begin
                        r_cnt <= r_cnt + 16'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (i_uword.rsel)
            RS_IDX:  w_res = r_idx;
            RS_RD:   w_res = w_rd;
            RS_CNT:  w_res = r_cnt;
            RS_END:  w_res = EndMark;
            default: w_res = 16'd0;
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_go && i_uword.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_go && i_uword.done) begin
            r_out_item.result_index <= w_res;
            r_out_item.status       <= i_uword.st;
        end
    end

    assign o_flags     = w_flags;
    assign o_out_free  = w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== hdl/fat_chain_engine_unit.sv =====
// Top level of the FAT chain engine: register port, sequencer and datapath.
// Depends on fce_pkg, fce_seq, fce_path and fat_chain_engine_unit_defines.svh.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------
//  input    | i_in_valid / o_in_ready      | i_in_item  (t_in_item)
//  output   | o_out_valid / i_out_ready    | o_out_item (t_out_item)
//  config   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One item at a time; every link-memory read costs a step before its data is used.
// Allocate scans entries in turn; free, find last and walk follow one link per pass;
// the next item is accepted only once the result of the last has been registered.
// Synchronous active-low reset clears control only; the link table is undefined
// until loaded and gets no clearing pass. A held output stalls only the final step.
`include "fat_chain_engine_unit_defines.svh"

module fat_chain_engine_unit #(
    parameter int unsigned TABLE_DEPTH = fce_pkg::DefDepth
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  fce_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output fce_pkg::t_out_item                o_out_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fce_pkg::CfgAddrWidth-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import fce_pkg::*;

    localparam logic [15:0] DepthN = 16'(TABLE_DEPTH);
    localparam logic [15:0] NReset =
        (TABLE_DEPTH < 8192) ? 16'(TABLE_DEPTH) : 16'd8192;

    logic [13:0] r_block_count;
    logic [15:0] r_n_used;
    logic [15:0] w_wr_count;
    logic        w_cfg_wr;
    logic        w_start;
    logic        w_busy;
    logic        w_go;
    logic        w_out_free;
    t_uword      w_uword;
    t_flags      w_flags;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready && !paddr[2];
    assign w_wr_count = {2'b00, pwdata[13:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= BlockCountReset;
            r_n_used      <= NReset;
        end else if (w_cfg_wr) begin
            r_block_count <= pwdata[13:0];
            r_n_used      <= (w_wr_count > DepthN) ? DepthN : w_wr_count;
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {18'd0, r_block_count};

    assign o_in_ready = !w_busy;
    assign w_start    = i_in_valid && o_in_ready;

    fce_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_func     (i_in_item.func),
        .i_flags    (w_flags),
        .i_out_free (w_out_free),
        .o_busy     (w_busy),
        .o_go       (w_go),
        .o_uword    (w_uword)
    );

    fce_path #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_path (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_item      (i_in_item),
        .i_n_used    (r_n_used),
        .i_uword     (w_uword),
        .i_go        (w_go),
        .o_flags     (w_flags),
        .o_out_free  (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    `FCE_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, w_start, w_busy, "accepted item did not start")
    `FCE_ASSERT_IMPLY(a_done_out, i_clk, i_rst_n, $fell(w_busy), o_out_valid, "finish without result")
    `FCE_ASSERT_IMPLY(a_out_src, i_clk, i_rst_n, $rose(o_out_valid), $past(w_busy), "stray result")
    `FCE_ASSERT_IMPLY(a_n_range, i_clk, i_rst_n, 1'b1, r_n_used <= DepthN, "entry count over depth")

endmodule

// ===== verif/fce_result_check.sv =====
// Result checker for fat_chain_engine_unit: tracks block_count from the register port,
// keeps its own link table, predicts each result and compares the output channel.
// Depends on fce_pkg.
module fce_result_check #(
    parameter logic [fce_pkg::CfgAddrWidth-1:0] BLOCK_COUNT_ADDR = '0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  fce_pkg::t_in_item                i_in_item,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  fce_pkg::t_out_item               i_out_item,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic                             i_pready,
    input  logic [fce_pkg::CfgAddrWidth-1:0] i_paddr,
    input  logic [31:0]                      i_pwdata,
    output int unsigned                      o_fail_count,
    output int unsigned                      o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import fce_pkg::*;

    logic [15:0] link_mem [DefDepth];
    logic [13:0] block_cnt;
    t_out_item   expected_q [$];
    int unsigned fail_tally;

    function automatic t_out_item apply_fat_op(input t_in_item it);
        int unsigned n;
        int unsigned pos;
        int unsigned nxt;
        int unsigned hops;
        int unsigned k;
        int unsigned slot;
        bit          found;
        bit          busy;
        logic [15:0] res;
        t_status     st;
        t_out_item   r;
        n   = (block_cnt > DefDepth) ? DefDepth : block_cnt;
        pos = it.chain_index;
        res = '0;
        st  = ST_OK;
        case (it.func)
            FnLoad: begin
                if (pos >= n) st = ST_BAD;
                else link_mem[pos] = it.entry_value;
            end
            FnRead: begin
                if (pos >= n) st = ST_BAD;
                else res = link_mem[pos];
            end
            FnAlloc: begin
                if (pos != EndMark && pos >= n) begin
                    st = ST_BAD;
                end else begin
                    found = 1'b0;
                    slot  = 0;
                    for (k = 0; k < n && !found; k++) begin
                        if (link_mem[k] == '0) begin
                            slot  = k;
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        st = ST_NOFREE;
                    end else begin
                        if (pos != EndMark) link_mem[pos] = 16'(slot);
                        link_mem[slot] = EndMark;
                        res = 16'(slot);
                    end
                end
            end
            FnFree: begin
                hops = 0;
                while (pos != EndMark && st == ST_OK) begin
                    if (pos >= n || hops >= n) begin
                        st = ST_BAD;
                    end else begin
                        nxt = link_mem[pos];
                        link_mem[pos] = '0;
                        pos = nxt;
                        hops++;
                    end
                end
            end
            FnLast: begin
                if (pos == EndMark) begin
                    res = EndMark;
                end else if (pos >= n) begin
                    st = ST_BAD;
                end else begin
                    hops = 0;
                    busy = 1'b1;
                    while (busy) begin
                        nxt = link_mem[pos];
                        if (nxt == EndMark) begin
                            res  = 16'(pos);
                            busy = 1'b0;
                        end else if (nxt >= n || hops + 1 >= n) begin
                            st   = ST_BAD;
                            busy = 1'b0;
                        end else begin
                            pos = nxt;
                            hops++;
                        end
                    end
                end
            end
            FnWalk: begin
                hops = 0;
                while (hops < it.block_steps && st == ST_OK) begin
                    if (pos == EndMark) st = ST_PASTEND;
                    else if (pos >= n || hops >= n) st = ST_BAD;
                    else begin
                        pos = link_mem[pos];
                        hops++;
                    end
                end
                if (st == ST_OK && pos != EndMark && pos >= n) st = ST_BAD;
                if (st == ST_OK) res = 16'(pos);
                else if (st == ST_PASTEND) res = EndMark;
            end
            default: st = ST_BAD;
        endcase
        r.result_index = res;
        r.status       = st;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            block_cnt = BlockCountReset;
            expected_q.delete();
            foreach (link_mem[k]) link_mem[k] = '0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result: result_index %h status %0d",
                           i_out_item.result_index, i_out_item.status);
                    fail_tally++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_out_item.result_index !== want.result_index) begin
                        $error("result_index mismatch: expected %h, got %h",
                               want.result_index, i_out_item.result_index);
                        fail_tally++;
                    end
                    if (i_out_item.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, i_out_item.status);
                        fail_tally++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == BLOCK_COUNT_ADDR)
                block_cnt = i_pwdata[13:0];
            if (i_in_valid && i_in_ready)
                expected_q.push_back(apply_fat_op(i_in_item));
        end
        o_outstanding <= expected_q.size();
        o_fail_count  <= fail_tally;
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for fat_chain_engine_unit: clock, reset, directed and random item
// stimulus with random idling on both channels, block_count phases and the verdict.
// Depends on fce_pkg, fat_chain_engine_unit and fce_result_check.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fce_pkg::*;

    localparam logic [2:0] FnSpareA = 3'd6;
    localparam logic [2:0] FnSpareB = 3'd7;
    localparam logic [CfgAddrWidth-1:0] BlockCountAddr = '0;
    localparam int unsigned RandPerPhase = 150;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    t_in_item                i_in_item   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    t_out_item               o_out_item;
    logic                    psel        = 1'b0;
    logic                    penable     = 1'b0;
    logic                    pwrite      = 1'b0;
    logic [CfgAddrWidth-1:0] paddr       = '0;
    logic [31:0]             pwdata      = '0;
    logic [31:0]             prdata;
    logic                    pready;

    int unsigned fail_count;
    int unsigned outstanding;
    bit          steady    = 1'b0;
    int unsigned loaded_to = 0;
    int unsigned used_n    = DefDepth;
    int unsigned phase_sizes [6] = '{3, 8, 17, 40, 64, 2};

    fat_chain_engine_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    fce_result_check #(
        .BLOCK_COUNT_ADDR (BlockCountAddr)
    ) u_result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_item    (o_out_item),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 33);
    end

    function automatic logic [15:0] pick_idx();
        return (used_n == 0) ? 16'($urandom) : 16'($urandom_range(used_n - 1));
    endfunction

    function automatic logic [15:0] fill_value(input bit sparse);
        int unsigned r;
        r = $urandom_range(99);
        if (sparse) begin
            if (r < 80) return '0;
            if (r < 92) return EndMark;
            if (r < 97) return pick_idx();
            return 16'($urandom);
        end
        if (r < 35) return '0;
        if (r < 50) return EndMark;
        if (r < 90) return pick_idx();
        return 16'($urandom);
    endfunction

    function automatic t_in_item rnd_item();
        t_in_item    it;
        int unsigned w;
        int unsigned r;
        int unsigned span;
        it.chain_index = 16'($urandom);
        it.entry_value = 16'($urandom);
        it.block_steps = 16'($urandom);
        w = $urandom_range(99);
        if (w < 14) it.func = FnLoad;
        else if (w < 24) it.func = FnRead;
        else if (w < 48) it.func = FnAlloc;
        else if (w < 60) it.func = FnFree;
        else if (w < 75) it.func = FnLast;
        else if (w < 97) it.func = FnWalk;
        else it.func = w[0] ? FnSpareA : FnSpareB;
        r = $urandom_range(99);
        if (r < 82) it.chain_index = pick_idx();
        else if (r < 90) it.chain_index = EndMark;
        if (it.func == FnAlloc && $urandom_range(99) < 35) it.chain_index = EndMark;
        if (it.func == FnLoad) it.entry_value = fill_value(1'b0);
        if (it.func == FnWalk) begin
            r    = $urandom_range(99);
            span = (used_n < 40) ? used_n : 40;
            if (r < 85) it.block_steps = 16'($urandom_range(span + 2));
            else if (r >= 95) it.block_steps = 16'hFFFF;
        end
        return it;
    endfunction

    // entered and left at a falling edge; valid stays up until the item is taken
    task automatic issue(input t_in_item it);
        while (!steady && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic op(input logic [2:0] f, input logic [15:0] idx,
                      input logic [15:0] val, input logic [15:0] steps);
        t_in_item it;
        it.func        = f;
        it.chain_index = idx;
        it.entry_value = val;
        it.block_steps = steps;
        issue(it);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_block_count(input logic [13:0] v);
        settle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= BlockCountAddr;
        pwdata  <= {18'($urandom), v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        used_n = (v > DefDepth) ? DefDepth : v;
        @(negedge i_clk);
    endtask

    // every entry in use gets loaded before anything can follow a link into it
    task automatic fill_table(input bit sparse);
        int unsigned k;
        for (k = loaded_to; k < used_n; k++)
            op(FnLoad, 16'(k), fill_value(sparse), 16'($urandom));
        if (used_n > loaded_to) loaded_to = used_n;
    endtask

    initial begin
        int unsigned p;
        int unsigned k;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset count: nothing here reads an entry other than 8191
        op(FnLoad,   16'd8191, 16'h1234, 16'd0);
        op(FnLoad,   16'd8192, 16'hFFFF, 16'hFFFF);
        op(FnRead,   16'd8191, 16'd0,    16'd0);
        op(FnRead,   16'hFFFF, 16'd0,    16'd0);
        op(FnAlloc,  16'hFFFE, 16'd0,    16'd0);
        op(FnFree,   EndMark,  16'd0,    16'd0);
        op(FnLast,   EndMark,  16'd0,    16'd0);
        op(FnWalk,   EndMark,  16'd0,    16'd1);
        op(FnWalk,   16'd8191, 16'd0,    16'd1);
        op(FnWalk,   16'd8192, 16'd0,    16'd0);
        op(FnSpareA, 16'd0,    16'd0,    16'd0);
        op(FnSpareB, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // no usable entries
        set_block_count(14'd0);
        op(FnAlloc, EndMark, 16'd0, 16'd0);
        op(FnLast,  16'd0,   16'd0, 16'd0);
        op(FnWalk,  EndMark, 16'd0, 16'hFFFF);

        // single entry: tail is the free slot, full table, exact landing, loops
        set_block_count(14'd1);
        op(FnLoad,  16'd0,   16'd0, 16'd0);
        loaded_to = 1;
        op(FnAlloc, 16'd0,   16'd0, 16'd0);
        op(FnAlloc, EndMark, 16'd0, 16'd0);
        op(FnWalk,  16'd0,   16'd0, 16'd1);
        op(FnWalk,  16'd0,   16'd0, 16'd2);
        op(FnLoad,  16'd0,   16'd0, 16'd0);
        op(FnLast,  16'd0,   16'd0, 16'd0);
        op(FnFree,  16'd0,   16'd0, 16'd0);

        for (p = 0; p < 6; p++) begin
            set_block_count(14'(phase_sizes[p]));
            fill_table(1'b0);
            steady = (p == 2);
            for (k = 0; k < RandPerPhase; k++) begin
                if (p == 1 && k == RandPerPhase / 2) settle();
                issue(rnd_item());
            end
            steady = 1'b0;
        end

        // count above depth is clamped; only entry 8191 is touched up here
        set_block_count(14'h3FFF);
        op(FnLoad,  16'd8192, 16'd0, 16'd0);
        op(FnRead,  16'd8191, 16'd0, 16'd0);
        op(FnWalk,  16'd8191, 16'd0, 16'd1);
        op(FnAlloc, 16'd8192, 16'd0, 16'd0);
        op(FnLast,  EndMark,  16'd0, 16'd0);
        set_block_count(14'd8192);
        op(FnLoad,  16'd8191, EndMark, 16'd0);
        op(FnLast,  16'd8191, 16'd0,   16'd0);
        op(FnFree,  16'd8191, 16'd0,   16'd0);
        op(FnRead,  16'd8191, 16'd0,   16'd0);

        settle();
        repeat (64) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/fce_pkg.sv
hdl/fce_ram.sv
hdl/fce_seq.sv
hdl/fce_path.sv
hdl/fat_chain_engine_unit.sv
verif/fce_result_check.sv
verif/tb.sv
